FILE: src/implicit_list_best_fit_allocator_defines.svh
// Assertion macros for the allocator.
`ifndef IMPLICIT_LIST_BEST_FIT_ALLOCATOR_DEFINES_SVH
`define IMPLICIT_LIST_BEST_FIT_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/ilbfa_pkg.sv
package ilbfa_pkg;

  localparam int HEAP_BYTES = 16384;
  localparam int WORD_COUNT = HEAP_BYTES / 4;
  localparam int IDX_W      = $clog2(WORD_COUNT);
  localparam int WORD_W     = 15;
  localparam int AW         = 20;
  localparam int PTR_W      = 14;
  localparam int REQ_W      = 16;
  localparam int CFG_W      = 15;
  localparam int REG_IDX_W  = 1;

  localparam logic [CFG_W-1:0] CHUNK_RESET = CFG_W'(4096);
  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(16384);

  typedef enum logic [1:0] {
    OPC_INIT    = 2'd0,
    OPC_MALLOC  = 2'd1,
    OPC_FREE    = 2'd2,
    OPC_REALLOC = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FAIL   = 2'd1,
    ST_NOINIT = 2'd2
  } status_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CHUNK = 1'b0,
    REG_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [PTR_W-1:0] block_ptr;
    logic [REQ_W-1:0] request_bytes;
  } in_item_t;

  typedef struct packed {
    logic [PTR_W-1:0] result_ptr;
    logic [1:0]       status;
    logic             copy_needed;
  } out_item_t;

  typedef enum logic [5:0] {
    CMD_NOP, CMD_LOAD, CMD_INIT0, CMD_IW0, CMD_IW4, CMD_IW8, CMD_IW12, CMD_INIT_OK,
    CMD_G0, CMD_G1, CMD_G2, CMD_G3, CMD_G4,
    CMD_M0, CMD_M1, CMD_M2, CMD_M3, CMD_M4, CMD_M5,
    CMD_MA1, CMD_MA2, CMD_MB1, CMD_MB2, CMD_MC1, CMD_MC2,
    CMD_F0, CMD_F1, CMD_F2,
    CMD_A0, CMD_W0, CMD_W1, CMD_BEST, CMD_GSEL,
    CMD_P0, CMD_P1,
    CMD_S1, CMD_S2, CMD_S3, CMD_S4, CMD_Q1, CMD_Q2,
    CMD_RES_BP, CMD_RES_PTR, CMD_SETCOPY,
    CMD_R0, CMD_R1, CMD_SHRINK
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       optr_zero;
    logic       req_zero;
    logic       initd;
    logic       lim_lt16;
    logic       grow_fail;
    logic       p_ge_brk;
    logic       rd_zero;
    logic       rd_alloc;
    logic       palloc;
    logic       best_zero;
    logic       blk_lt_need;
    logic       split_ok;
    logic       res_zero;
  } dp_stat_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_I0, S_IW0, S_IW4, S_IW8, S_IW12, S_INIT_OK,
    S_G0, S_G1, S_G2, S_G3, S_G4,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_MA1, S_MA2, S_MB1, S_MB2, S_MC1, S_MC2,
    S_F0, S_F1, S_F2,
    S_A0, S_W0, S_W1, S_WDONE, S_BEST, S_GSEL,
    S_P0, S_P1, S_P2,
    S_S1, S_S2, S_S3, S_S4, S_Q1, S_Q2,
    S_RES_BP, S_MALLOC_RET, S_SETCOPY,
    S_R0, S_R1, S_R2, S_RES_PTR, S_SHRINK, S_FIN
  } ctl_state_t;

  typedef enum logic [2:0] {
    FL_INIT, FL_MALLOC, FL_FREE, FL_REALLOC, FL_RGROW, FL_RSHRINK
  } flow_t;

endpackage

FILE: src/ilbfa_dp.sv
`include "implicit_list_best_fit_allocator_defines.svh"

module ilbfa_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  ilbfa_pkg::dp_cmd_t          cmd,
  input  ilbfa_pkg::in_item_t         in_data,
  input  logic [ilbfa_pkg::CFG_W-1:0] chunk,
  input  logic [ilbfa_pkg::CFG_W-1:0] limit,
  output ilbfa_pkg::dp_stat_t         stat,
  output ilbfa_pkg::out_item_t        res_item
);
  import ilbfa_pkg::*;

  logic [WORD_W-1:0] mem [WORD_COUNT];
  logic [WORD_W-1:0] rdata;
  logic              rd_ok;

  logic [1:0]       opc;
  logic [PTR_W-1:0] optr;
  logic [REQ_W-1:0] req;
  logic             copy;
  logic             initd;
  logic             palloc;
  logic [AW-1:0]    res, brk, bp, prev, psz, cur, nxt, nsz, total, tmp, gn, p, best, bsz, need;

  logic [WORD_W-1:0] rv;
  logic [AW-1:0]     rs, lim, rnd, gn_calc, maddr, mwdata, optr_x;
  logic              mrd, mwr, in_rng;

  function automatic logic [AW-1:0] round_block(input logic [REQ_W-1:0] r);
    logic [REQ_W:0] t;
    t = {1'b0, r} + (REQ_W+1)'(15);
    if (r <= REQ_W'(8)) return AW'(16);
    return AW'({t[REQ_W:3], 3'b000});
  endfunction

  assign rv      = rd_ok ? rdata : '0;
  assign rs      = AW'({rv[WORD_W-1:3], 3'b000});
  assign lim     = (AW'(limit) > AW'(HEAP_BYTES)) ? AW'(HEAP_BYTES) : AW'(limit);
  assign rnd     = {tmp[AW-1:3], 3'b000} + (tmp[2] ? AW'(8) : '0);
  assign gn_calc = (rnd == '0) ? AW'(8) : rnd;
  assign optr_x  = AW'(optr);
  assign in_rng  = maddr < AW'(HEAP_BYTES);

  always_comb begin
    maddr  = '0;
    mwdata = '0;
    mrd    = 1'b0;
    mwr    = 1'b0;
    case (cmd)
      CMD_IW0:  begin mwr = 1'b1; maddr = AW'(0);  mwdata = '0;       end
      CMD_IW4:  begin mwr = 1'b1; maddr = AW'(4);  mwdata = AW'(9);   end
      CMD_IW8:  begin mwr = 1'b1; maddr = AW'(8);  mwdata = AW'(9);   end
      CMD_IW12: begin mwr = 1'b1; maddr = AW'(12); mwdata = AW'(1);   end
      CMD_G2:   begin mwr = 1'b1; maddr = bp - AW'(4);      mwdata = gn; end
      CMD_G3:   begin mwr = 1'b1; maddr = bp + gn - AW'(8); mwdata = gn; end
      CMD_G4:   begin mwr = 1'b1; maddr = bp + gn - AW'(4); mwdata = AW'(1); end
      CMD_M0:   begin mrd = 1'b1; maddr = bp - AW'(8); end
      CMD_M1:   begin mrd = 1'b1; maddr = bp - rs - AW'(4); end
      CMD_M2:   begin mrd = 1'b1; maddr = prev + rs - AW'(8); end
      CMD_M3:   begin mrd = 1'b1; maddr = bp - AW'(4); end
      CMD_M4:   begin mrd = 1'b1; maddr = bp + rs - AW'(4); end
      CMD_MA1:  begin mwr = 1'b1; maddr = bp - AW'(4);          mwdata = total; end
      CMD_MA2:  begin mwr = 1'b1; maddr = bp + total - AW'(8);  mwdata = total; end
      CMD_MB1:  begin mwr = 1'b1; maddr = bp + cur - AW'(8);    mwdata = total; end
      CMD_MB2:  begin mwr = 1'b1; maddr = prev - AW'(4);        mwdata = total; end
      CMD_MC1:  begin mwr = 1'b1; maddr = prev - AW'(4);        mwdata = total; end
      CMD_MC2:  begin mwr = 1'b1; maddr = nxt + nsz - AW'(8);   mwdata = total; end
      CMD_F0:   begin mrd = 1'b1; maddr = optr_x - AW'(4); end
      CMD_F1:   begin mwr = 1'b1; maddr = bp - AW'(4);          mwdata = rs;  end
      CMD_F2:   begin mwr = 1'b1; maddr = bp + tmp - AW'(8);    mwdata = tmp; end
      CMD_W0:   begin mrd = 1'b1; maddr = p - AW'(4); end
      CMD_P0:   begin mrd = 1'b1; maddr = bp - AW'(4); end
      CMD_R0:   begin mrd = 1'b1; maddr = optr_x - AW'(4); end
      CMD_S1:   begin mwr = 1'b1; maddr = bp + need - AW'(4);   mwdata = cur - need; end
      CMD_S2:   begin mwr = 1'b1; maddr = bp + cur - AW'(8);    mwdata = cur - need; end
      CMD_S3:   begin mwr = 1'b1; maddr = bp - AW'(4);          mwdata = need | AW'(1); end
      CMD_S4:   begin mwr = 1'b1; maddr = bp + need - AW'(8);   mwdata = need | AW'(1); end
      CMD_Q1:   begin mwr = 1'b1; maddr = bp - AW'(4);          mwdata = cur | AW'(1); end
      CMD_Q2:   begin mwr = 1'b1; maddr = bp + cur - AW'(8);    mwdata = cur | AW'(1); end
      default: begin
        mrd = 1'b0;
        mwr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mwr && in_rng) begin
      mem[maddr[IDX_W+1:2]] <= WORD_W'(mwdata);
    end
    if (mrd) begin
      rdata <= mem[maddr[IDX_W+1:2]];
      rd_ok <= in_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brk   <= '0;
      initd <= 1'b0;
    end else begin
      case (cmd)
        CMD_INIT0: begin brk <= '0; initd <= 1'b0; end
        CMD_IW12:  brk <= AW'(16);
        CMD_INIT_OK: initd <= 1'b1;
        CMD_G4:    brk <= brk + gn;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        opc  <= in_data.opcode;
        optr <= in_data.block_ptr;
        req  <= in_data.request_bytes;
        res  <= '0;
        copy <= 1'b0;
      end
      CMD_IW12: tmp <= AW'(chunk);
      CMD_G0:   gn <= gn_calc;
      CMD_G1:   bp <= brk;
      CMD_M1:   prev <= bp - rs;
      CMD_M2:   psz <= rs;
      CMD_M3:   palloc <= rv[0];
      CMD_M4: begin
        cur <= rs;
        nxt <= bp + rs;
      end
      CMD_M5: begin
        nsz <= rs;
        if (palloc) total <= cur + rs;
        else if (rv[0]) total <= cur + psz;
        else total <= cur + rs + psz;
      end
      CMD_MB2, CMD_MC2: bp <= prev;
      CMD_F0:   bp <= optr_x;
      CMD_F1:   tmp <= rs;
      CMD_A0: begin
        need <= round_block(req);
        p    <= AW'(8);
        best <= '0;
        bsz  <= '1;
      end
      CMD_W1: begin
        if (!rv[0] && rs >= need && rs < bsz) begin
          best <= p;
          bsz  <= rs;
        end
        p <= p + rs;
      end
      CMD_BEST:    bp <= best;
      CMD_GSEL:    tmp <= (need > AW'(chunk)) ? need : AW'(chunk);
      CMD_P1:      cur <= rs;
      CMD_R0:      need <= round_block(req);
      CMD_R1: begin
        cur <= rs;
        bp  <= optr_x;
      end
      CMD_RES_BP:  res <= bp;
      CMD_RES_PTR: res <= optr_x;
      CMD_SETCOPY: copy <= 1'b1;
      CMD_SHRINK:  bp <= bp + need;
      default: ;
    endcase
  end

  always_comb begin
    stat.opcode      = opc;
    stat.optr_zero   = optr == '0;
    stat.req_zero    = req == '0;
    stat.initd       = initd;
    stat.lim_lt16    = lim < AW'(16);
    stat.grow_fail   = (brk + gn) > lim;
    stat.p_ge_brk    = p >= brk;
    stat.rd_zero     = rs == '0;
    stat.rd_alloc    = rv[0];
    stat.palloc      = palloc;
    stat.best_zero   = best == '0;
    stat.blk_lt_need = cur < need;
    stat.split_ok    = cur > need + AW'(8);
    stat.res_zero    = res == '0;
  end

  always_comb begin
    res_item.result_ptr  = res[PTR_W-1:0];
    res_item.copy_needed = copy;
    if (opc == OPC_INIT) res_item.status = initd ? ST_OK : ST_FAIL;
    else if (!initd) res_item.status = ST_NOINIT;
    else if (opc == OPC_FREE) res_item.status = ST_OK;
    else res_item.status = (res == '0) ? ST_FAIL : ST_OK;
  end

  `ASSERT_IMPL(a_brk_bound, clk, rst, initd, brk >= AW'(24) && brk <= AW'(HEAP_BYTES))

endmodule

FILE: src/ilbfa_ctrl.sv
module ilbfa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_room,
  output logic                emit,
  input  ilbfa_pkg::dp_stat_t stat,
  output ilbfa_pkg::dp_cmd_t  cmd
);
  import ilbfa_pkg::*;

  ctl_state_t state, state_next;
  flow_t      flow, flow_next;
  logic       from_grow, from_grow_next;
  ctl_state_t merge_exit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      flow      <= FL_MALLOC;
      from_grow <= 1'b0;
    end else begin
      state     <= state_next;
      flow      <= flow_next;
      from_grow <= from_grow_next;
    end
  end

  always_comb begin
    if (!from_grow) merge_exit = S_FIN;
    else if (flow == FL_INIT) merge_exit = S_INIT_OK;
    else merge_exit = S_P0;
  end

  always_comb begin
    state_next     = state;
    flow_next      = flow;
    from_grow_next = from_grow;
    cmd            = CMD_NOP;
    emit           = 1'b0;
    in_stall       = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.opcode == OPC_INIT) begin
          flow_next  = FL_INIT;
          state_next = S_I0;
        end else if (!stat.initd) begin
          state_next = S_FIN;
        end else if (stat.opcode == OPC_MALLOC) begin
          flow_next  = FL_MALLOC;
          state_next = S_A0;
        end else if (stat.opcode == OPC_FREE) begin
          flow_next  = FL_FREE;
          state_next = stat.optr_zero ? S_FIN : S_F0;
        end else if (stat.optr_zero) begin
          flow_next  = FL_MALLOC;
          state_next = S_A0;
        end else if (stat.req_zero) begin
          flow_next  = FL_FREE;
          state_next = S_RES_PTR;
        end else begin
          flow_next  = FL_REALLOC;
          state_next = S_R0;
        end
      end
      S_I0: begin
        cmd        = CMD_INIT0;
        state_next = stat.lim_lt16 ? S_FIN : S_IW0;
      end
      S_IW0:  begin cmd = CMD_IW0;  state_next = S_IW4;  end
      S_IW4:  begin cmd = CMD_IW4;  state_next = S_IW8;  end
      S_IW8:  begin cmd = CMD_IW8;  state_next = S_IW12; end
      S_IW12: begin cmd = CMD_IW12; state_next = S_G0;   end
      S_INIT_OK: begin cmd = CMD_INIT_OK; state_next = S_FIN; end
      S_G0: begin cmd = CMD_G0; state_next = S_G1; end
      S_G1: begin
        cmd = CMD_G1;
        if (stat.grow_fail) state_next = (flow == FL_INIT) ? S_FIN : S_MALLOC_RET;
        else state_next = S_G2;
      end
      S_G2: begin cmd = CMD_G2; state_next = S_G3; end
      S_G3: begin cmd = CMD_G3; state_next = S_G4; end
      S_G4: begin
        cmd            = CMD_G4;
        from_grow_next = 1'b1;
        state_next     = S_M0;
      end
      S_M0: begin cmd = CMD_M0; state_next = S_M1; end
      S_M1: begin cmd = CMD_M1; state_next = S_M2; end
      S_M2: begin cmd = CMD_M2; state_next = S_M3; end
      S_M3: begin cmd = CMD_M3; state_next = S_M4; end
      S_M4: begin cmd = CMD_M4; state_next = S_M5; end
      S_M5: begin
        cmd = CMD_M5;
        if (stat.palloc && stat.rd_alloc) state_next = merge_exit;
        else if (stat.palloc) state_next = S_MA1;
        else if (stat.rd_alloc) state_next = S_MB1;
        else state_next = S_MC1;
      end
      S_MA1: begin cmd = CMD_MA1; state_next = S_MA2; end
      S_MA2: begin cmd = CMD_MA2; state_next = merge_exit; end
      S_MB1: begin cmd = CMD_MB1; state_next = S_MB2; end
      S_MB2: begin cmd = CMD_MB2; state_next = merge_exit; end
      S_MC1: begin cmd = CMD_MC1; state_next = S_MC2; end
      S_MC2: begin cmd = CMD_MC2; state_next = merge_exit; end
      S_F0: begin cmd = CMD_F0; state_next = S_F1; end
      S_F1: begin cmd = CMD_F1; state_next = S_F2; end
      S_F2: begin
        cmd            = CMD_F2;
        from_grow_next = 1'b0;
        state_next     = S_M0;
      end
      S_A0: begin
        cmd        = CMD_A0;
        state_next = stat.req_zero ? S_MALLOC_RET : S_W0;
      end
      S_W0: begin
        cmd        = CMD_W0;
        state_next = stat.p_ge_brk ? S_WDONE : S_W1;
      end
      S_W1: begin
        cmd        = CMD_W1;
        state_next = stat.rd_zero ? S_WDONE : S_W0;
      end
      S_WDONE: state_next = stat.best_zero ? S_GSEL : S_BEST;
      S_BEST: begin cmd = CMD_BEST; state_next = S_P0; end
      S_GSEL: begin cmd = CMD_GSEL; state_next = S_G0; end
      S_P0: begin cmd = CMD_P0; state_next = S_P1; end
      S_P1: begin cmd = CMD_P1; state_next = S_P2; end
      S_P2: state_next = stat.split_ok ? S_S1 : S_Q1;
      S_S1: begin cmd = CMD_S1; state_next = S_S2; end
      S_S2: begin cmd = CMD_S2; state_next = S_S3; end
      S_S3: begin cmd = CMD_S3; state_next = S_S4; end
      S_S4: begin
        cmd        = CMD_S4;
        state_next = (flow == FL_RSHRINK) ? S_SHRINK : S_RES_BP;
      end
      S_Q1: begin cmd = CMD_Q1; state_next = S_Q2; end
      S_Q2: begin cmd = CMD_Q2; state_next = S_RES_BP; end
      S_RES_BP: begin cmd = CMD_RES_BP; state_next = S_MALLOC_RET; end
      S_MALLOC_RET: begin
        state_next = (flow == FL_RGROW && !stat.res_zero) ? S_SETCOPY : S_FIN;
      end
      S_SETCOPY: begin cmd = CMD_SETCOPY; state_next = S_F0; end
      S_R0: begin cmd = CMD_R0; state_next = S_R1; end
      S_R1: begin cmd = CMD_R1; state_next = S_R2; end
      S_R2: begin
        if (stat.blk_lt_need) begin
          flow_next  = FL_RGROW;
          state_next = S_A0;
        end else begin
          flow_next  = FL_RSHRINK;
          state_next = S_RES_PTR;
        end
      end
      S_RES_PTR: begin
        cmd = CMD_RES_PTR;
        if (flow == FL_FREE) state_next = S_F0;
        else state_next = stat.split_ok ? S_S1 : S_FIN;
      end
      S_SHRINK: begin
        cmd            = CMD_SHRINK;
        from_grow_next = 1'b0;
        state_next     = S_M0;
      end
      S_FIN: begin
        if (out_room) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: src/implicit_list_best_fit_allocator.sv
// Time from input transfer to result depends on the op: a malloc walks every heap block
//   and grows the heap when no free block fits; a realloc that grows may move the block.
//   Ops before init and free of null go straight to the result.
// Throughput: one operation in flight; the next transfer is taken once the result is registered.
// Heap words sit in a single-port memory, one access per cycle, which sets the pace.
// Reset (synchronous): clears break, initialized flag and controller; chunk 4096, limit 16384.
`include "implicit_list_best_fit_allocator_defines.svh"

module implicit_list_best_fit_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ilbfa_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ilbfa_pkg::out_item_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ilbfa_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [ilbfa_pkg::CFG_W-1:0]     cfg_data
);
  import ilbfa_pkg::*;

  logic [CFG_W-1:0] chunk, limit;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  out_item_t        res_item;
  logic             emit, out_room;

  assign cfg_ready = 1'b1;
  assign out_room  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= CHUNK_RESET;
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_CHUNK: chunk <= cfg_data;
        REG_LIMIT: limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= res_item;
    end
  end

  ilbfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_room (out_room),
    .emit     (emit),
    .stat     (stat),
    .cmd      (cmd)
  );

  ilbfa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .chunk    (chunk),
    .limit    (limit),
    .stat     (stat),
    .res_item (res_item)
  );

  `ASSERT_NEXT(a_emit_shows, clk, rst, emit, out_valid)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

endmodule
